/* rtl/core/i2crm_pkg.sv */
// Shared types and constants of the I2C register master.
`default_nettype none

package i2crm_pkg;

    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WAIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_WAIT  = 2'd1;

    localparam logic [7:0] SHORT_WAIT_RST = 8'd1;
    localparam logic [7:0] LONG_WAIT_RST  = 8'd3;

    // Address byte bit 0: read or write flag
    localparam logic [7:0] RW_FLAG = 8'h01;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_PROBE = 2'd3
    } cmd_t;

    // One queued beat, with the front end's classification attached
    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  slave_addr;
        logic [15:0] reg_addr;
        logic        wide_reg_addr;
        logic [7:0]  byte_count;
        logic [7:0]  wr_data;
        logic        sda_in;
        logic        start;      // command present
        logic        zero_fail;  // read or write with zero count
    } item_t;

endpackage

`default_nettype wire

/* rtl/core/i2crm_if.sv */
// Channel interfaces of the I2C register master: item, result and configuration.
`default_nettype none

interface i2crm_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  slave_addr;
    logic [15:0] reg_addr;
    logic        wide_reg_addr;
    logic [7:0]  byte_count;
    logic [7:0]  wr_data;
    logic        sda_in;

    modport source (output valid, cmd, slave_addr, reg_addr, wide_reg_addr, byte_count,
                    wr_data, sda_in, input ready);
    modport sink   (input valid, cmd, slave_addr, reg_addr, wide_reg_addr, byte_count,
                    wr_data, sda_in, output ready);
endinterface

interface i2crm_result_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic [7:0] rd_data;
    logic       rd_valid;
    logic       data_taken;
    logic       done_res;
    logic       ack_ok;
    logic       busy_res;

    modport source (output valid, scl_out, sda_out, rd_data, rd_valid, data_taken,
                    done_res, ack_ok, busy_res, input ready);
    modport sink   (input valid, scl_out, sda_out, rd_data, rd_valid, data_taken,
                    done_res, ack_ok, busy_res, output ready);
endinterface

interface i2crm_cfg_if;
    import i2crm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/i2crm_front.sv */
// Front end: accept item beats, classify the command and queue them for the sequencer.
`default_nettype none

module i2crm_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    i2crm_item_if.sink           item,
    output i2crm_pkg::item_t     q_item,
    output logic                 q_valid,
    input  wire logic            q_pop
);
    import i2crm_pkg::*;

    item_t       entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    item_t       classified;
    logic        push;
    logic        pop;

    always_comb
    begin
        classified.cmd           = item.cmd;
        classified.slave_addr    = item.slave_addr;
        classified.reg_addr      = item.reg_addr;
        classified.wide_reg_addr = item.wide_reg_addr;
        classified.byte_count    = item.byte_count;
        classified.wr_data       = item.wr_data;
        classified.sda_in        = item.sda_in;
        classified.start         = (item.cmd != CMD_TICK);
        classified.zero_fail     = (item.cmd inside {CMD_READ, CMD_WRITE})
                                   && (item.byte_count == 8'd0);
    end

    assign item.ready = (count_reg != 2'd2);
    assign push       = item.valid && item.ready;
    assign q_valid    = (count_reg != 2'd0);
    assign pop        = q_pop && q_valid;
    assign q_item     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= classified;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && !pop) |=> (count_reg == 2'd2))
        else $error("full queue lost an entry");

endmodule

`default_nettype wire

/* rtl/core/i2crm_seq.sv */
// Back end: bus sequencer stepped once per queued beat, with the result register.
`default_nettype none

module i2crm_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire i2crm_pkg::item_t q_item,
    input  wire logic            q_valid,
    output logic                 q_pop,
    i2crm_cfg_if.sink            cfg,
    i2crm_result_if.source       result
);
    import i2crm_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_ST_A   = 5'd1,
        PH_ST_B   = 5'd2,
        PH_ST_C   = 5'd3,
        PH_TX_LO  = 5'd4,
        PH_TX_HI  = 5'd5,
        PH_ACK_HI = 5'd6,
        PH_ACK_LO = 5'd7,
        PH_GAP    = 5'd8,
        PH_RX_HI  = 5'd9,
        PH_RX_LO  = 5'd10,
        PH_MA_A   = 5'd11,
        PH_MA_B   = 5'd12,
        PH_MA_C   = 5'd13,
        PH_MA_D   = 5'd14,
        PH_NK_HI  = 5'd15,
        PH_NK_LO  = 5'd16,
        PH_SP_A   = 5'd17,
        PH_SP_B   = 5'd18,
        PH_SP_C   = 5'd19
    } phase_t;

    typedef enum logic [2:0] {
        ST_SLA_W  = 3'd0,
        ST_REG_HI = 3'd1,
        ST_REG_LO = 3'd2,
        ST_SLA_R  = 3'd3,
        ST_DATA   = 3'd4
    } stage_t;

    logic [7:0]  short_wait_reg, long_wait_reg;

    phase_t      phase_reg, phase_next, go_ph;
    stage_t      stage_reg, stage_next;
    logic [2:0]  bitpos_reg, bitpos_next;
    logic [7:0]  bytes_reg, bytes_next, bytes_dec;
    logic [7:0]  delay_reg, delay_next;
    logic [7:0]  shift_reg, shift_next;
    logic        acked_reg, acked_next;
    logic [7:0]  hslave_reg, hslave_next;
    logic [15:0] hreg_reg, hreg_next;
    logic        hwide_reg, hwide_next;
    logic [1:0]  hkind_reg, hkind_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        go;
    logic [7:0]  wait_sel;

    logic        out_valid_reg;
    logic [7:0]  res_rd_reg, res_rd_next;
    logic        res_rv_reg, res_rv_next;
    logic        res_tk_reg, res_tk_next;
    logic        res_dn_reg, res_dn_next;
    logic        res_ok_reg, res_ok_next;

    logic        step;

    assign cfg.ready = 1'b1;
    assign step      = q_valid && (!out_valid_reg || result.ready);
    assign q_pop     = step;
    assign bytes_dec = (bytes_reg != 8'd0) ? bytes_reg - 8'd1 : 8'd0;

    always_comb
    begin
        phase_next  = phase_reg;
        stage_next  = stage_reg;
        bitpos_next = bitpos_reg;
        bytes_next  = bytes_reg;
        delay_next  = delay_reg;
        shift_next  = shift_reg;
        acked_next  = acked_reg;
        hslave_next = hslave_reg;
        hreg_next   = hreg_reg;
        hwide_next  = hwide_reg;
        hkind_next  = hkind_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        res_rd_next = 8'd0;
        res_rv_next = 1'b0;
        res_tk_next = 1'b0;
        res_dn_next = 1'b0;
        res_ok_next = 1'b0;
        go          = 1'b0;
        go_ph       = PH_IDLE;
        wait_sel    = short_wait_reg;

        if (phase_reg == PH_IDLE)
        begin
            if (q_item.start)
            begin
                if (q_item.zero_fail)
                    res_dn_next = 1'b1;
                else
                begin
                    hkind_next  = q_item.cmd;
                    hslave_next = q_item.slave_addr;
                    hreg_next   = q_item.reg_addr;
                    hwide_next  = q_item.wide_reg_addr;
                    bytes_next  = q_item.byte_count;
                    acked_next  = 1'b1;
                    stage_next  = ST_SLA_W;
                    go          = 1'b1;
                    go_ph       = PH_ST_A;
                end
            end
        end
        else if (delay_reg != 8'd0)
            delay_next = delay_reg - 8'd1;
        else
        begin
            case (phase_reg)
                PH_ST_A:   begin go = 1'b1; go_ph = PH_ST_B; end
                PH_ST_B:   begin go = 1'b1; go_ph = PH_ST_C; end
                PH_ST_C:
                begin
                    shift_next  = (stage_reg == ST_SLA_R) ? (hslave_reg | RW_FLAG)
                                                          : (hslave_reg & ~RW_FLAG);
                    bitpos_next = 3'd7;
                    go          = 1'b1;
                    go_ph       = PH_TX_LO;
                end
                PH_TX_LO:  begin go = 1'b1; go_ph = PH_TX_HI; end
                PH_TX_HI:
                begin
                    go = 1'b1;
                    if (bitpos_reg == 3'd0)
                        go_ph = PH_ACK_HI;
                    else
                    begin
                        bitpos_next = bitpos_reg - 3'd1;
                        go_ph       = PH_TX_LO;
                    end
                end
                PH_ACK_HI:
                begin
                    if (q_item.sda_in)
                        acked_next = 1'b0;
                    go    = 1'b1;
                    go_ph = PH_ACK_LO;
                end
                PH_ACK_LO: begin go = 1'b1; go_ph = PH_GAP; end
                PH_GAP:
                begin
                    go          = 1'b1;
                    bitpos_next = 3'd7;
                    case (stage_reg)
                        ST_SLA_W:
                        begin
                            if (hkind_reg == CMD_PROBE)
                            begin
                                bitpos_next = bitpos_reg;
                                go_ph       = PH_SP_A;
                            end
                            else if (hwide_reg)
                            begin
                                stage_next = ST_REG_HI;
                                shift_next = hreg_reg[15:8];
                                go_ph      = PH_TX_LO;
                            end
                            else
                            begin
                                stage_next = ST_REG_LO;
                                shift_next = hreg_reg[7:0];
                                go_ph      = PH_TX_LO;
                            end
                        end
                        ST_REG_HI:
                        begin
                            stage_next = ST_REG_LO;
                            shift_next = hreg_reg[7:0];
                            go_ph      = PH_TX_LO;
                        end
                        ST_REG_LO:
                        begin
                            if (hkind_reg == CMD_READ)
                            begin
                                bitpos_next = bitpos_reg;
                                stage_next  = ST_SLA_R;
                                go_ph       = PH_ST_A;
                            end
                            else
                            begin
                                stage_next  = ST_DATA;
                                res_tk_next = 1'b1;
                                shift_next  = q_item.wr_data;
                                go_ph       = PH_TX_LO;
                            end
                        end
                        ST_SLA_R:
                        begin
                            stage_next = ST_DATA;
                            shift_next = 8'd0;
                            go_ph      = PH_RX_HI;
                        end
                        default:
                        begin
                            bytes_next = bytes_dec;
                            if (hkind_reg == CMD_READ)
                            begin
                                shift_next = 8'd0;
                                go_ph      = PH_RX_HI;
                            end
                            else if (bytes_dec == 8'd0)
                            begin
                                bitpos_next = bitpos_reg;
                                go_ph       = PH_SP_A;
                            end
                            else
                            begin
                                res_tk_next = 1'b1;
                                shift_next  = q_item.wr_data;
                                go_ph       = PH_TX_LO;
                            end
                        end
                    endcase
                end
                PH_RX_HI:
                begin
                    shift_next = {shift_reg[6:0], q_item.sda_in};
                    if (bitpos_reg == 3'd0)
                    begin
                        res_rv_next = 1'b1;
                        res_rd_next = {shift_reg[6:0], q_item.sda_in};
                    end
                    go    = 1'b1;
                    go_ph = PH_RX_LO;
                end
                PH_RX_LO:
                begin
                    go = 1'b1;
                    if (bitpos_reg != 3'd0)
                    begin
                        bitpos_next = bitpos_reg - 3'd1;
                        go_ph       = PH_RX_HI;
                    end
                    else if (bytes_reg > 8'd1)
                        go_ph = PH_MA_A;
                    else
                        go_ph = PH_NK_HI;
                end
                PH_MA_A:   begin go = 1'b1; go_ph = PH_MA_B; end
                PH_MA_B:   begin go = 1'b1; go_ph = PH_MA_C; end
                PH_MA_C:   begin go = 1'b1; go_ph = PH_MA_D; end
                PH_MA_D:   begin go = 1'b1; go_ph = PH_GAP; end
                PH_NK_HI:  begin go = 1'b1; go_ph = PH_NK_LO; end
                PH_NK_LO:  begin go = 1'b1; go_ph = PH_SP_A; end
                PH_SP_A:   begin go = 1'b1; go_ph = PH_SP_B; end
                PH_SP_B:   begin go = 1'b1; go_ph = PH_SP_C; end
                PH_SP_C:
                begin
                    res_dn_next = 1'b1;
                    res_ok_next = acked_reg;
                    phase_next  = PH_IDLE;
                    bitpos_next = 3'd7;
                    delay_next  = 8'd0;
                    scl_next    = 1'b1;
                    sda_next    = 1'b1;
                end
                default:
                begin
                    phase_next  = PH_IDLE;
                    bitpos_next = 3'd7;
                    delay_next  = 8'd0;
                    scl_next    = 1'b1;
                    sda_next    = 1'b1;
                end
            endcase
        end

        // Enter a new phase: set the lines and load its wait
        if (go)
        begin
            phase_next = go_ph;
            case (go_ph)
                PH_ST_A:   begin scl_next = 1'b1; sda_next = 1'b1; end
                PH_ST_B:   sda_next = 1'b0;
                PH_ST_C:   begin scl_next = 1'b0; wait_sel = long_wait_reg; end
                PH_TX_LO:  begin scl_next = 1'b0; sda_next = shift_next[bitpos_next]; end
                PH_TX_HI:  scl_next = 1'b1;
                PH_ACK_HI: begin scl_next = 1'b1; sda_next = 1'b1; end
                PH_ACK_LO: scl_next = 1'b0;
                PH_RX_HI:  begin scl_next = 1'b1; sda_next = 1'b1; end
                PH_RX_LO:  scl_next = 1'b0;
                PH_MA_A:   begin scl_next = 1'b0; sda_next = 1'b0; end
                PH_MA_B:   begin scl_next = 1'b1; wait_sel = long_wait_reg; end
                PH_MA_C:   begin sda_next = 1'b0; wait_sel = long_wait_reg; end
                PH_MA_D:   scl_next = 1'b0;
                PH_NK_HI:  begin scl_next = 1'b1; sda_next = 1'b1; end
                PH_NK_LO:  scl_next = 1'b0;
                PH_SP_A:   sda_next = 1'b0;
                PH_SP_B:   scl_next = 1'b1;
                PH_SP_C:   sda_next = 1'b1;
                default:   ;
            endcase
            delay_next = (wait_sel == 8'd0) ? 8'd0 : wait_sel - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_wait_reg <= SHORT_WAIT_RST;
            long_wait_reg  <= LONG_WAIT_RST;
            phase_reg      <= PH_IDLE;
            stage_reg      <= ST_SLA_W;
            bitpos_reg     <= 3'd7;
            bytes_reg      <= 8'd0;
            delay_reg      <= 8'd0;
            shift_reg      <= 8'd0;
            acked_reg      <= 1'b1;
            hslave_reg     <= 8'd0;
            hreg_reg       <= 16'd0;
            hwide_reg      <= 1'b0;
            hkind_reg      <= 2'd0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            out_valid_reg  <= 1'b0;
            res_rd_reg     <= 8'd0;
            res_rv_reg     <= 1'b0;
            res_tk_reg     <= 1'b0;
            res_dn_reg     <= 1'b0;
            res_ok_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_SHORT_WAIT)
                    short_wait_reg <= cfg.data;
                else if (cfg.index == CFG_LONG_WAIT)
                    long_wait_reg <= cfg.data;
            end
            if (step)
            begin
                phase_reg     <= phase_next;
                stage_reg     <= stage_next;
                bitpos_reg    <= bitpos_next;
                bytes_reg     <= bytes_next;
                delay_reg     <= delay_next;
                shift_reg     <= shift_next;
                acked_reg     <= acked_next;
                hslave_reg    <= hslave_next;
                hreg_reg      <= hreg_next;
                hwide_reg     <= hwide_next;
                hkind_reg     <= hkind_next;
                scl_reg       <= scl_next;
                sda_reg       <= sda_next;
                res_rd_reg    <= res_rd_next;
                res_rv_reg    <= res_rv_next;
                res_tk_reg    <= res_tk_next;
                res_dn_reg    <= res_dn_next;
                res_ok_reg    <= res_ok_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.scl_out    = scl_reg;
    assign result.sda_out    = sda_reg;
    assign result.rd_data    = res_rd_reg;
    assign result.rd_valid   = res_rv_reg;
    assign result.data_taken = res_tk_reg;
    assign result.done_res   = res_dn_reg;
    assign result.ack_ok     = res_ok_reg;
    assign result.busy_res   = (phase_reg != PH_IDLE);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_dn_reg) |-> (phase_reg == PH_IDLE))
        else $error("done reported while still busy");
    a_ok_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_ok_reg |-> res_dn_reg)
        else $error("ack_ok without done");
    a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (scl_reg && sda_reg && delay_reg == 8'd0))
        else $error("bus not released while idle");
    a_rd_tk_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_rv_reg && res_tk_reg))
        else $error("read byte and write take on the same beat");

endmodule

`default_nettype wire

/* rtl/core/i2c_register_master.sv */
// Top level of the I2C register master: front queue and bus sequencer.
//
//  channel  dir  beat payload
//  -------  ---  --------------------------------------------------------------
//  item     in   cmd, slave_addr, reg_addr, wide_reg_addr, byte_count, wr_data,
//                sda_in  (one beat = one bus delay tick)
//  result   out  scl_out, sda_out, rd_data, rd_valid, data_taken, done_res,
//                ack_ok, busy_res  (one beat per item beat, in order)
//  cfg      in   index, data  (0 short_wait, 1 long_wait; always ready)
//
// Throughput is one item beat per clock unless the result register is stalled; the
// sequencer advances one step per beat using only counters, so nothing else inside
// limits the rate below one per cycle. Beats pass the two-entry front queue, then
// the result register. Reset (rst_n, async low) empties the queue, idles the sequencer
// with both lines released and loads short_wait 1, long_wait 3.
// A stalled result holds in its register while the queue keeps taking beats; item
// ready drops only when both queue entries are occupied.
`default_nettype none

module i2c_register_master (
    input  wire logic clk,
    input  wire logic rst_n,
    i2crm_item_if.sink     item,
    i2crm_result_if.source result,
    i2crm_cfg_if.sink      cfg
);
    import i2crm_pkg::*;

    item_t q_item;
    logic  q_valid;
    logic  q_pop;

    // Front: take item beats, flag command start and zero-count failure, queue them
    i2crm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    // Back: step the bus sequencer once per queued beat and register the result
    i2crm_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .cfg     (cfg),
        .result  (result)
    );

endmodule

`default_nettype wire
